### hw/rtl/kdlp_pkg.sv
// Shared types and constants for the key debouncer with long-press detection.
`timescale 1ns / 1ps
`default_nettype none

package kdlp_pkg;

  localparam int unsigned NumKeys  = 5;
  localparam int unsigned KeyIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaskW    = 5;

  localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgActiveMsk = 2'd2;

  localparam logic [CfgDataW-1:0] DebounceRst  = 16'd20;
  localparam logic [CfgDataW-1:0] LongPressRst = 16'd1000;
  localparam logic [MaskW-1:0]    ActiveMskRst = 5'd30;

  typedef enum logic [4:0] {
    PhReleased = 5'b00001,
    PhPre      = 5'b00010,
    PhPressed  = 5'b00100,
    PhLong     = 5'b01000,
    PhPost     = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    EvPressed  = 2'd0,
    EvLong     = 2'd1,
    EvReleased = 2'd2
  } evkind_e;

  typedef struct packed {
    logic [4:0]  key_levels;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [KeyIdxW-1:0] key_index;
    logic               last_event;
  } evt_t;

  // Events of one poll: a valid bit and a kind per key.
  typedef struct packed {
    logic [NumKeys-1:0]      valid;
    logic [NumKeys-1:0][1:0] kind;
  } rec_t;

endpackage

`default_nettype wire

### hw/rtl/kdlp_front.sv
// Front end: configuration registers, per-key phase machines and event classification.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_front #(
  parameter int unsigned TickWidth = 32
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [kdlp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [kdlp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                             accept_i,
  input  kdlp_pkg::poll_t                 poll_i,
  output kdlp_pkg::rec_t                  rec_o,
  output logic                            rec_valid_o
);
  import kdlp_pkg::*;

  logic [CfgDataW-1:0]  deb_q, long_q;
  logic [MaskW-1:0]     mask_q;
  phase_e               phase_q [NumKeys];
  phase_e               phase_d [NumKeys];
  logic [TickWidth-1:0] start_q [NumKeys];
  logic [TickWidth-1:0] start_d [NumKeys];
  logic [TickWidth-1:0] elapsed [NumKeys];
  logic [NumKeys-1:0]   pressed, deb_gt, long_gt;
  logic [TickWidth-1:0] now;

  assign now = poll_i.now_ms[TickWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DebounceRst;
      long_q <= LongPressRst;
      mask_q <= ActiveMskRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce:  deb_q  <= cfg_wdata_i;
        CfgLongPress: long_q <= cfg_wdata_i;
        CfgActiveMsk: mask_q <= cfg_wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NumKeys; i++) begin
      pressed[i] = (poll_i.key_levels[i] == mask_q[i]);
      elapsed[i] = now - start_q[i];
      deb_gt[i]  = elapsed[i] > TickWidth'(deb_q);
      long_gt[i] = elapsed[i] > TickWidth'(long_q);
      phase_d[i] = phase_q[i];
      start_d[i] = start_q[i];
      rec_o.valid[i] = 1'b0;
      rec_o.kind[i]  = EvPressed;
      unique case (phase_q[i])
        PhPre: begin
          if (!pressed[i]) begin
            phase_d[i] = PhReleased;
          end else if (deb_gt[i]) begin
            phase_d[i]     = PhPressed;
            start_d[i]     = now;
            rec_o.valid[i] = 1'b1;
            rec_o.kind[i]  = EvPressed;
          end
        end
        PhPressed: begin
          if (!pressed[i]) begin
            phase_d[i] = PhPost;
            start_d[i] = now;
          end else if (long_gt[i]) begin
            phase_d[i]     = PhLong;
            start_d[i]     = now;
            rec_o.valid[i] = 1'b1;
            rec_o.kind[i]  = EvLong;
          end
        end
        PhLong: begin
          if (!pressed[i]) begin
            phase_d[i] = PhPost;
            start_d[i] = now;
          end
        end
        PhPost: begin
          if (deb_gt[i]) begin
            phase_d[i]     = PhReleased;
            start_d[i]     = '0;
            rec_o.valid[i] = 1'b1;
            rec_o.kind[i]  = EvReleased;
          end
        end
        default: begin
          if (pressed[i]) begin
            phase_d[i] = PhPre;
            start_d[i] = now;
          end else begin
            phase_d[i] = PhReleased;
          end
        end
      endcase
    end
  end

  assign rec_valid_o = |rec_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) begin
        phase_q[i] <= PhReleased;
        start_q[i] <= '0;
      end
    end else if (accept_i) begin
      for (int i = 0; i < NumKeys; i++) begin
        phase_q[i] <= phase_d[i];
        start_q[i] <= start_d[i];
      end
    end
  end

  a_press_enters_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && rec_o.valid[0] && rec_o.kind[0] == EvPressed |=> phase_q[0] == PhPressed)
    else $error("key 0 pressed event without entering pressed phase");

  a_release_clears_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && rec_o.valid[0] && rec_o.kind[0] == EvReleased |=> start_q[0] == '0)
    else $error("key 0 released without clearing its start tick");

endmodule

`default_nettype wire

### hw/rtl/kdlp_fifo.sv
// Short queue of per-poll event records between front and back.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  kdlp_pkg::rec_t  data_i,
  output logic            full_o,
  input  wire             pop_i,
  output kdlp_pkg::rec_t  data_o,
  output logic            empty_o
);
  import kdlp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> cnt_q == CntW'(Depth))
    else $error("record queue lost its fill level");

endmodule

`default_nettype wire

### hw/rtl/kdlp_back.sv
// Back end: serializes one poll's events in key order into the result register.
`timescale 1ns / 1ps
`default_nettype none

module kdlp_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  kdlp_pkg::rec_t  rec_i,
  input  wire             rec_empty_i,
  output logic            rec_pop_o,
  output kdlp_pkg::evt_t  evt_o,
  output logic            empty_o,
  input  wire             pop_i
);
  import kdlp_pkg::*;

  logic [NumKeys-1:0]      rem_q, rem_d, lowest, rem_after;
  logic [NumKeys-1:0][1:0] kind_q, kind_d;
  logic                    out_valid_q, out_valid_d;
  evt_t                    out_q, out_d;
  logic                    load, emit;
  logic [KeyIdxW-1:0]      idx;
  logic [1:0]              kind_sel;

  assign lowest    = rem_q & (~rem_q + 1'b1);
  assign rem_after = rem_q & ~lowest;
  assign load      = !out_valid_q || pop_i;
  assign emit      = load && (rem_q != '0);
  assign rec_pop_o = !rec_empty_i && ((rem_q == '0) || (emit && rem_after == '0));

  always_comb begin
    idx      = '0;
    kind_sel = EvPressed;
    for (int i = 0; i < NumKeys; i++) begin
      if (lowest[i]) begin
        idx      = idx | KeyIdxW'(i);
        kind_sel = kind_sel | kind_q[i];
      end
    end
  end

  always_comb begin
    rem_d       = rem_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      rem_d            = rem_after;
      out_valid_d      = 1'b1;
      out_d.event_kind = kind_sel;
      out_d.key_index  = idx;
      out_d.last_event = (rem_after == '0);
    end else if (load) begin
      out_valid_d = 1'b0;
    end
    if (rec_pop_o) begin
      rem_d  = rec_i.valid;
      kind_d = rec_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    out_q  <= out_d;
  end

  assign evt_o   = out_q;
  assign empty_o = !out_valid_q;

  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last_event |-> rem_q != '0)
    else $error("non-final event shown with no events left for the poll");

  a_record_has_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o |-> rec_i.valid != '0)
    else $error("empty event record taken from queue");

endmodule

`default_nettype wire

### hw/rtl/key_debounce_long_press.sv
// Top level of the key debouncer with long-press detection.
//
//   channel  handshake               payload
//   poll     push / full             poll_i      (key_levels, now_ms)
//   event    empty / pop             evt_o       (event_kind, key_index, last_event)
//   config   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A poll is taken whenever the record queue has room; all keys update at once.
// A poll with events enters a two-entry queue; the back end sends one event per cycle
// while the result port is popped, so a poll with k events (at most 5) shows them in turn.
// Its first event passes the record queue, the pending-key register and the result register.
// Reset puts every key in the released phase and loads the default registers.
// Polls keep flowing while results stall until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press #(
  parameter int unsigned TickWidth = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [kdlp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [kdlp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire                            push,
  output logic                           full,
  input  kdlp_pkg::poll_t                poll_i,
  output logic                           empty,
  input  wire                            pop,
  output kdlp_pkg::evt_t                 evt_o
);
  import kdlp_pkg::*;

  rec_t rec_in, rec_out;
  logic rec_valid, rec_full, rec_empty, rec_pop, accept;

  assign accept = push && !rec_full;
  assign full   = rec_full;

  kdlp_front #(
    .TickWidth (TickWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .poll_i      (poll_i),
    .rec_o       (rec_in),
    .rec_valid_o (rec_valid)
  );

  kdlp_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && rec_valid),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .empty_o (rec_empty)
  );

  kdlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .evt_o       (evt_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire
